// File: design/fprt_pkg.sv
// ----------------------------------------------------------------------------
// fprt_pkg
// Shared constants for the finder pattern run tracker.
// ----------------------------------------------------------------------------
package fprt_pkg;

   localparam int LINE_LENGTH       = 4096;
   localparam int RUN_WIDTH_DEFAULT = 16;

   localparam int POS_WIDTH    = 12;
   localparam int RADIUS_WIDTH = 11;
   localparam int CENTRE_WIDTH = 13;
   localparam int MINR_WIDTH   = 8;
   localparam int STEP_WIDTH   = 3;

   localparam int CSR_ADDR_WIDTH = 2;
   localparam int CSR_DATA_WIDTH = 32;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_MIN_RADIUS = 2'd0;

   localparam logic [STEP_WIDTH-1:0] STEP_CALIBRATING = 3'd7;
   localparam logic [STEP_WIDTH-1:0] STEP_FIRST       = 3'd0;
   localparam logic [STEP_WIDTH-1:0] STEP_WIDE        = 3'd2;
   localparam logic [STEP_WIDTH-1:0] STEP_DONE        = 3'd5;

   // floor(x / 7) = (x * DIV7_RECIP) >> DIV7_SHIFT, exact for 12-bit x
   localparam int                   DIV7_SHIFT = 14;
   localparam logic [POS_WIDTH-1:0] DIV7_RECIP = 12'd2341;
   localparam int                   DIV7_PROD_WIDTH = 2 * POS_WIDTH;
   localparam int                   QUOT_WIDTH = DIV7_PROD_WIDTH - DIV7_SHIFT;

endpackage

// File: design/finder_pattern_run_tracker.sv
// ----------------------------------------------------------------------------
// finder_pattern_run_tracker
// 1:1:3:1:1 run detector for binarized scan lines, one pixel per beat.
// ----------------------------------------------------------------------------
// One pixel beat is accepted every clock while req_stall is low and yields
// exactly one result beat. The pixel is registered when it is accepted.
// When the output can advance, the run tracker (run length, unit length,
// match step) updates from the pixel register and the result register
// takes the hit flag, radius and centre. The radius is the span divided by
// seven with a single reciprocal multiply. The result is held while
// rsp_stall is high. With the pixel and result registers both full and the
// output stalled, req_stall rises in the same cycle. The tracker state
// updates once per pixel, so throughput is one pixel per clock while the
// output is not stalled. The user writes min_radius over the CSR port at
// byte address 0 only while idle; the block itself does not enforce this.
module finder_pattern_run_tracker #(
   parameter int RUN_WIDTH = fprt_pkg::RUN_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_pixel_bright,
   input  logic [fprt_pkg::POS_WIDTH-1:0]       req_position,
   input  logic                                 req_restart,

   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_found,
   output logic signed [fprt_pkg::RADIUS_WIDTH-1:0] rsp_radius,
   output logic signed [fprt_pkg::CENTRE_WIDTH-1:0] rsp_centre,

   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [fprt_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [fprt_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [fprt_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                 csr_pready
);

   localparam int POS_W  = fprt_pkg::POS_WIDTH;
   localparam int CMP_W  = RUN_WIDTH + 4;
   localparam int SPAN_W = POS_W + 1;
   localparam int QUOT_W = fprt_pkg::QUOT_WIDTH;
   localparam int PROD_W = fprt_pkg::DIV7_PROD_WIDTH;
   localparam logic [RUN_WIDTH-1:0] RUN_MAX = {RUN_WIDTH{1'b1}};
   localparam logic [POS_W-1:0] POS_MASK = POS_W'(fprt_pkg::LINE_LENGTH - 1);

   // ---------------- CSR ----------------
   logic [fprt_pkg::MINR_WIDTH-1:0] min_radius_ff, min_radius_in;

   assign csr_pready = 1'b1;

   always_comb begin
      min_radius_in = min_radius_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_paddr == fprt_pkg::CSR_MIN_RADIUS) begin
         min_radius_in = csr_pwdata[fprt_pkg::MINR_WIDTH-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == fprt_pkg::CSR_MIN_RADIUS) begin
         csr_prdata = fprt_pkg::CSR_DATA_WIDTH'(min_radius_ff);
      end
   end

   // ---------------- pipeline control ----------------
   logic in_v_ff, in_v_in;
   logic out_v_ff, out_v_in;
   logic out_adv, in_adv;

   assign out_adv   = !out_v_ff || !rsp_stall;
   assign in_adv    = !in_v_ff || out_adv;
   assign req_stall = !in_adv;

   assign in_v_in  = in_adv ? req_valid : in_v_ff;
   assign out_v_in = out_adv ? in_v_ff : out_v_ff;

   // ---------------- pixel register ----------------
   logic             bright_ff, bright_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             restart_ff, restart_in;

   assign bright_in  = in_adv ? req_pixel_bright : bright_ff;
   assign pos_in     = in_adv ? (req_position & POS_MASK) : pos_ff;
   assign restart_in = in_adv ? req_restart : restart_ff;

   // ---------------- run tracker ----------------
   logic [fprt_pkg::STEP_WIDTH-1:0] step_ff, step_in;
   logic                            colour_ff, colour_in;
   logic [RUN_WIDTH-1:0]            run_ff, run_in;
   logic [RUN_WIDTH-1:0]            unit_ff, unit_in;
   logic [POS_W-1:0]                pstart_ff, pstart_in;

   logic [fprt_pkg::STEP_WIDTH-1:0] step_cur, step_nxt;
   logic                            colour_cur;
   logic [RUN_WIDTH-1:0]            run_cur, unit_cur;
   logic [POS_W-1:0]                pstart_cur;
   logic [CMP_W-1:0]                want, want3, twice;
   logic                            is_match, done_now;

   always_comb begin
      step_cur   = step_ff;
      colour_cur = colour_ff;
      run_cur    = run_ff;
      unit_cur   = unit_ff;
      pstart_cur = pstart_ff;
      if (restart_ff) begin
         step_cur   = fprt_pkg::STEP_CALIBRATING;
         colour_cur = 1'b0;
         run_cur    = '0;
         unit_cur   = '0;
         pstart_cur = '0;
      end

      if (step_cur == fprt_pkg::STEP_WIDE) begin
         want = CMP_W'(unit_cur) + (CMP_W'(unit_cur) << 1);
      end else begin
         want = CMP_W'(unit_cur);
      end
      want3    = want + (want << 1);
      twice    = CMP_W'(run_cur) << 1;
      is_match = (twice < want3) && (twice > want);

      step_in   = step_cur;
      colour_in = colour_cur;
      run_in    = run_cur;
      unit_in   = unit_cur;
      pstart_in = pstart_cur;
      step_nxt  = step_cur;
      done_now  = 1'b0;

      if (bright_ff != colour_cur) begin
         if (step_cur == fprt_pkg::STEP_CALIBRATING) begin
            step_nxt  = fprt_pkg::STEP_FIRST;
            unit_in   = run_cur;
            pstart_in = pos_ff;
         end else if (is_match) begin
            step_nxt = step_cur + 1'b1;
         end else if (colour_cur) begin
            step_nxt = fprt_pkg::STEP_FIRST;
         end else begin
            step_nxt = fprt_pkg::STEP_CALIBRATING;
         end
         colour_in = !colour_cur;
         if (step_nxt == fprt_pkg::STEP_DONE) begin
            step_in  = fprt_pkg::STEP_CALIBRATING;
            done_now = 1'b1;
            run_in   = '0;
         end else begin
            step_in = step_nxt;
            run_in  = RUN_WIDTH'(1);
         end
      end else if (run_cur != RUN_MAX) begin
         run_in = run_cur + 1'b1;
      end

      if (!(in_v_ff && out_adv)) begin
         step_in   = step_ff;
         colour_in = colour_ff;
         run_in    = run_ff;
         unit_in   = unit_ff;
         pstart_in = pstart_ff;
      end
   end

   // ---------------- radius and centre ----------------
   logic signed [SPAN_W-1:0] span;
   logic [PROD_W-1:0]        prod;
   logic [QUOT_W-1:0]        quot;
   logic                     span_pos, hit;
   logic [SPAN_W-1:0]        seven_r, half_r;
   logic                     found_ff, found_in;
   logic signed [fprt_pkg::RADIUS_WIDTH-1:0] radius_ff, radius_in;
   logic signed [fprt_pkg::CENTRE_WIDTH-1:0] centre_ff, centre_in;

   always_comb begin
      span     = SPAN_W'(pos_ff) - SPAN_W'(pstart_cur);
      span_pos = !span[SPAN_W-1] && (span != '0);
      prod     = PROD_W'(span[POS_W-1:0]) * PROD_W'(fprt_pkg::DIV7_RECIP);
      quot     = prod[PROD_W-1:fprt_pkg::DIV7_SHIFT];
      hit      = done_now && span_pos && (quot > QUOT_W'(min_radius_ff));
      seven_r  = (SPAN_W'(quot) << 3) - SPAN_W'(quot);
      half_r   = (seven_r + 1'b1) >> 1;

      found_in  = found_ff;
      radius_in = radius_ff;
      centre_in = centre_ff;
      if (out_adv) begin
         found_in  = hit;
         radius_in = hit ? fprt_pkg::RADIUS_WIDTH'(quot) : '0;
         centre_in = hit ? (fprt_pkg::CENTRE_WIDTH'(pos_ff) -
                            fprt_pkg::CENTRE_WIDTH'(half_r))
                         : '0;
      end
   end

   assign rsp_valid  = out_v_ff;
   assign rsp_found  = found_ff;
   assign rsp_radius = radius_ff;
   assign rsp_centre = centre_ff;

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         min_radius_ff <= '0;
         in_v_ff       <= 1'b0;
         out_v_ff      <= 1'b0;
         step_ff       <= fprt_pkg::STEP_CALIBRATING;
         colour_ff     <= 1'b0;
         run_ff        <= '0;
         unit_ff       <= '0;
         pstart_ff     <= '0;
      end else begin
         min_radius_ff <= min_radius_in;
         in_v_ff       <= in_v_in;
         out_v_ff      <= out_v_in;
         step_ff       <= step_in;
         colour_ff     <= colour_in;
         run_ff        <= run_in;
         unit_ff       <= unit_in;
         pstart_ff     <= pstart_in;
      end
   end

   always_ff @(posedge clock) begin
      bright_ff  <= bright_in;
      pos_ff     <= pos_in;
      restart_ff <= restart_in;
      found_ff   <= found_in;
      radius_ff  <= radius_in;
      centre_ff  <= centre_in;
   end

endmodule

// File: tb/fprt_hit_checker.sv
// ----------------------------------------------------------------------------
// fprt_hit_checker
// Scoreboard for the finder pattern run tracker.
// ----------------------------------------------------------------------------
// Watches the pixel, result and CSR channels. Each accepted pixel beat runs
// through a cycle-free model of the run tracker and its result is queued.
// Each accepted result beat is compared field by field with the oldest
// queued result. CSR writes update the local min_radius copy, and CSR reads
// are checked against it. The error count and the queue depth go to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fprt_hit_checker #(
   parameter int RUN_WIDTH = fprt_pkg::RUN_WIDTH_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,

   input  logic                                     req_valid,
   input  logic                                     req_stall,
   input  logic                                     req_pixel_bright,
   input  logic [fprt_pkg::POS_WIDTH-1:0]           req_position,
   input  logic                                     req_restart,

   input  logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   input  logic                                     rsp_found,
   input  logic signed [fprt_pkg::RADIUS_WIDTH-1:0] rsp_radius,
   input  logic signed [fprt_pkg::CENTRE_WIDTH-1:0] rsp_centre,

   input  logic                                     csr_psel,
   input  logic                                     csr_penable,
   input  logic                                     csr_pwrite,
   input  logic [fprt_pkg::CSR_ADDR_WIDTH-1:0]      csr_paddr,
   input  logic [fprt_pkg::CSR_DATA_WIDTH-1:0]      csr_pwdata,
   input  logic [fprt_pkg::CSR_DATA_WIDTH-1:0]      csr_prdata,
   input  logic                                     csr_pready,

   output int                                       errors,
   output int                                       pending
);

   localparam int RUN_MAX     = (2 ** RUN_WIDTH) - 1;
   localparam int MAX_REPORTS = 10;
   localparam int WIDE_RATIO  = 3;
   localparam int CW          = fprt_pkg::CENTRE_WIDTH;

   typedef struct {
      logic                                     found;
      logic signed [fprt_pkg::RADIUS_WIDTH-1:0] radius;
      logic signed [fprt_pkg::CENTRE_WIDTH-1:0] centre;
   } pixel_result_type;

   logic [fprt_pkg::STEP_WIDTH-1:0] step;
   logic                            run_bright;
   logic [RUN_WIDTH-1:0]            run_len;
   logic [RUN_WIDTH-1:0]            unit_len;
   logic [fprt_pkg::POS_WIDTH-1:0]  start_pos;
   logic [fprt_pkg::MINR_WIDTH-1:0] min_radius;

   pixel_result_type pixel_results_q[$];

   initial begin
      errors  = 0;
      pending = 0;
   end

   function automatic void clear_tracker();
      step       = fprt_pkg::STEP_CALIBRATING;
      run_bright = 1'b0;
      run_len    = '0;
      unit_len   = '0;
      start_pos  = '0;
   endfunction

   task automatic flag_error(input string msg);
      errors++;
      if (errors <= MAX_REPORTS) begin
         $display("ERROR at %0t: %s", $realtime, msg);
      end
   endtask

   task automatic check_field(input string name, input logic [CW-1:0] want,
                              input logic [CW-1:0] got);
      if (got !== want) begin
         flag_error($sformatf("%s mismatch: expected %0d, got %0d",
                              name, $signed(want), $signed(got)));
      end
   endtask

   // Advances the tracker by one pixel and returns the result it produces.
   function automatic pixel_result_type track_pixel(
         input logic bright, input logic [fprt_pkg::POS_WIDTH-1:0] pos,
         input logic restart);
      pixel_result_type res;
      logic             done;
      int unsigned      want;
      int unsigned      twice;
      int               span;
      int               r;
      res.found  = 1'b0;
      res.radius = '0;
      res.centre = '0;
      done       = 1'b0;
      if (restart) begin
         clear_tracker();
      end
      if (bright != run_bright) begin
         if (step == fprt_pkg::STEP_CALIBRATING) begin
            step      = fprt_pkg::STEP_FIRST;
            unit_len  = run_len;
            start_pos = pos;
         end else begin
            want = unit_len;
            if (step == fprt_pkg::STEP_WIDE) begin
               want = WIDE_RATIO * unit_len;
            end
            twice = 2 * run_len;
            if (twice < 3 * want && twice > want) begin
               step = step + 1'b1;
            end else begin
               step = run_bright ? fprt_pkg::STEP_FIRST : fprt_pkg::STEP_CALIBRATING;
            end
         end
         run_bright = !run_bright;
         run_len    = '0;
         if (step == fprt_pkg::STEP_DONE) begin
            span = int'(pos) - int'(start_pos);
            r    = span / 7;
            step = fprt_pkg::STEP_CALIBRATING;
            done = 1'b1;
            if (r > int'(min_radius)) begin
               res.found  = 1'b1;
               res.radius = fprt_pkg::RADIUS_WIDTH'(r);
               res.centre = CW'(int'(pos) - (7 * r + 1) / 2);
            end
         end
         if (!done && run_len < RUN_MAX) begin
            run_len = run_len + 1'b1;
         end
      end else if (run_len < RUN_MAX) begin
         run_len = run_len + 1'b1;
      end
      return res;
   endfunction

   always @(posedge clock) begin
      pixel_result_type exp_res;
      pixel_result_type new_res;
      if (reset) begin
         clear_tracker();
         min_radius = '0;
         pixel_results_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               if (csr_paddr == fprt_pkg::CSR_MIN_RADIUS) begin
                  min_radius = csr_pwdata[fprt_pkg::MINR_WIDTH-1:0];
               end
            end else if (csr_paddr == fprt_pkg::CSR_MIN_RADIUS &&
                         csr_prdata !== fprt_pkg::CSR_DATA_WIDTH'(min_radius)) begin
               flag_error($sformatf("min_radius readback: expected %0d, got %0d",
                                    min_radius, csr_prdata));
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (pixel_results_q.size() == 0) begin
               flag_error($sformatf("unexpected result beat: found %0b radius %0d centre %0d",
                                    rsp_found, rsp_radius, rsp_centre));
            end else begin
               exp_res = pixel_results_q.pop_front();
               check_field("found", CW'(exp_res.found), CW'(rsp_found));
               check_field("radius", CW'(exp_res.radius), CW'(rsp_radius));
               check_field("centre", exp_res.centre, rsp_centre);
            end
         end
         if (req_valid && !req_stall) begin
            new_res         = track_pixel(req_pixel_bright, req_position, req_restart);
            pixel_results_q = {pixel_results_q, new_res};
         end
      end
      pending = pixel_results_q.size();
   end

endmodule

// File: tb/finder_pattern_run_tracker_tb.sv
// ----------------------------------------------------------------------------
// finder_pattern_run_tracker_tb
// Top-level testbench for the finder pattern run tracker.
// ----------------------------------------------------------------------------
// Drives pixel beats made of 1:1:3:1:1 run patterns with random unit and
// jittered run lengths, plus noise runs, restarts and position jumps. Covers
// line wrap and the min_radius boundary, over phases with sender gaps,
// receiver stalls and one long output hold. Checking is done by
// fprt_hit_checker; this module makes stimulus and reports the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module finder_pattern_run_tracker_tb;

   localparam int PW              = fprt_pkg::POS_WIDTH;
   localparam int DW              = fprt_pkg::CSR_DATA_WIDTH;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int PHASE_ITEMS     = 240;
   localparam int TAIL_ITEMS      = 60;
   localparam int WIDE_RUN        = 2;
   localparam int WIDE_RATIO      = 3;
   localparam int PATTERN_RUNS    = 5;
   localparam int BOUNDARY_RADIUS = 12;

   logic                                     clock = 1'b0;
   logic                                     reset;
   logic                                     req_valid;
   logic                                     req_stall;
   logic                                     req_pixel_bright;
   logic [PW-1:0]                            req_position;
   logic                                     req_restart;
   logic                                     rsp_valid;
   logic                                     rsp_stall;
   logic                                     rsp_found;
   logic signed [fprt_pkg::RADIUS_WIDTH-1:0] rsp_radius;
   logic signed [fprt_pkg::CENTRE_WIDTH-1:0] rsp_centre;
   logic                                     csr_psel;
   logic                                     csr_penable;
   logic                                     csr_pwrite;
   logic [fprt_pkg::CSR_ADDR_WIDTH-1:0]      csr_paddr;
   logic [DW-1:0]                            csr_pwdata;
   logic [DW-1:0]                            csr_prdata;
   logic                                     csr_pready;

   int            mismatches;
   int            outstanding;
   int            idle_pct     = 0;
   int            stall_pct    = 0;
   int            hold_request = 0;
   int            hold_left    = 0;
   int            quiet_cycles = 0;
   int            sent         = 0;
   logic [PW-1:0] line_pos     = '0;

   finder_pattern_run_tracker uut (.*);

   fprt_hit_checker chk (.*, .errors(mismatches), .pending(outstanding));

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Output stall: random, or held for a counted stretch on request.
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_pixel(input logic bright, input logic restart);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_pixel_bright <= bright;
      req_position     <= line_pos;
      req_restart      <= restart;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      line_pos = line_pos + 1'b1;
      sent++;
   endtask

   task automatic send_run(input logic bright, input int len, input logic restart);
      for (int i = 0; i < len; i++) begin
         send_pixel(bright, restart && i == 0);
      end
   endtask

   // Run length around ku: mostly inside the tolerance, some on its edges,
   // some anywhere.
   function automatic int pick_len(input int ku, input int clean_pct);
      int lo;
      int hi;
      int sel;
      lo  = ku / 2 + 1;
      hi  = (3 * ku - 1) / 2;
      sel = $urandom_range(99);
      if (sel < clean_pct) begin
         return $urandom_range(hi, lo);
      end else if (sel < clean_pct + (100 - clean_pct) / 2) begin
         return ($urandom_range(1) == 1 || lo == 1) ? hi + 1 : lo - 1;
      end
      return $urandom_range(3 * ku + 2, 1);
   endfunction

   // Dark calibration run, five alternating runs, then the closing dark pixel.
   task automatic send_pattern(input int unit, input int clean_pct, input logic restart,
                               input logic exact);
      int ku;
      send_run(1'b0, unit, restart);
      for (int k = 0; k < PATTERN_RUNS; k++) begin
         ku = (k == WIDE_RUN) ? WIDE_RATIO * unit : unit;
         send_run(k % 2 == 0, exact ? ku : pick_len(ku, clean_pct), 1'b0);
      end
      send_pixel(1'b0, 1'b0);
   endtask

   task automatic random_traffic(input int count);
      int target;
      int sel;
      target = sent + count;
      while (sent < target) begin
         sel = $urandom_range(99);
         if (sel < 70) begin
            send_pattern(($urandom_range(99) < 85) ? $urandom_range(4, 1) : $urandom_range(20, 5),
                         85, $urandom_range(99) < 40, 1'b0);
         end else if (sel < 85) begin
            send_run(1'($urandom_range(1)), $urandom_range(12, 1), $urandom_range(99) < 10);
         end else begin
            if ($urandom_range(1) == 1) begin
               line_pos = PW'($urandom);
            end
            send_pixel(1'($urandom_range(1)), $urandom_range(99) < 30);
         end
      end
   endtask

   task automatic csr_access(input logic write, input logic [DW-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= fprt_pkg::CSR_MIN_RADIUS;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_min_radius(input int value);
      csr_access(1'b1, DW'(value));
      csr_access(1'b0, '0);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_pixel_bright = 1'b0;
      req_position     = '0;
      req_restart      = 1'b0;
      rsp_stall        = 1'b0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: clean unit-one pattern, pattern across the line wrap,
      // failed bright and dark runs, restart on a bright pixel
      csr_access(1'b0, '0);
      line_pos = '0;
      send_pattern(1, 100, 1'b1, 1'b1);
      line_pos = PW'(4093);
      send_pattern(1, 100, 1'b0, 1'b1);
      send_run(1'b0, 2, 1'b1);
      send_run(1'b1, 3, 1'b0);
      send_run(1'b0, 1, 1'b0);
      send_pixel(1'b1, 1'b1);
      drain();

      // full-rate input with one long output hold
      set_min_radius($urandom_range(3, 0));
      hold_request = 120;
      random_traffic(PHASE_ITEMS);
      drain();

      set_min_radius($urandom_range(6, 0));
      idle_pct = 84;
      random_traffic(PHASE_ITEMS);
      drain();

      set_min_radius($urandom_range(6, 0));
      idle_pct  = 0;
      stall_pct = 84;
      random_traffic(PHASE_ITEMS);
      drain();

      set_min_radius($urandom_range(6, 0));
      idle_pct  = 23;
      stall_pct = 23;
      random_traffic(PHASE_ITEMS);
      drain();

      // radius at the min_radius limit, then one above it
      idle_pct  = 0;
      stall_pct = 0;
      set_min_radius(BOUNDARY_RADIUS);
      line_pos = PW'($urandom_range(3800, 0));
      send_pattern(BOUNDARY_RADIUS, 100, 1'b1, 1'b1);
      send_pattern(BOUNDARY_RADIUS + 1, 100, 1'b0, 1'b1);
      drain();

      set_min_radius(0);
      send_pattern(2, 100, 1'b1, 1'b1);
      random_traffic(TAIL_ITEMS);

      req_valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// File: filelist.f
design/fprt_pkg.sv
design/finder_pattern_run_tracker.sv
tb/fprt_hit_checker.sv
tb/finder_pattern_run_tracker_tb.sv
